FILE: hw/rtl/dfu_iv_pkg.sv
// ----------------------------------------------------------------------------
// dfu_iv_pkg
// Shared types, constants and functions of the DfuSe image validator.
// ----------------------------------------------------------------------------
package dfu_iv_pkg;

	// Default width of the byte position counter.
	localparam int unsigned POSITION_BITS_DEF = 24;

	// Offsets and lengths inside the image file.
	localparam int unsigned PREFIX_LEN = 5;
	localparam int unsigned TARGET_AT  = 11;
	localparam int unsigned TARGET_LEN = 6;
	localparam int unsigned ADDRESS_AT = 285;
	localparam int unsigned SIZE_AT    = 289;
	localparam int unsigned HEADER_END = 293;

	localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
	localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

	// Suffix signature, read from the window eight bytes before the end.
	localparam logic [7:0] SUFFIX_U = 8'h55;
	localparam logic [7:0] SUFFIX_F = 8'h46;
	localparam logic [7:0] SUFFIX_D = 8'h44;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_PREFIX = 3'd2,
		ST_TARGET = 3'd3,
		ST_SUFFIX = 3'd4,
		ST_CRC    = 3'd5
	} status_t;

	// Per-item handshake control seen by the state modules.
	typedef struct packed {
		logic fire;
		logic last;
	} step_t;

	// Header flags, already including the byte being processed.
	typedef struct packed {
		logic prefix_ok;
		logic target_ok;
		logic len_lt5;
		logic len_lt17;
		logic len_lt293;
	} hdr_flags_t;

	// Character of "DfuSe" at a given index.
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h44;
			3'd1:    c = 8'h66;
			3'd2:    c = 8'h75;
			3'd3:    c = 8'h53;
			3'd4:    c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Character of "Target" at a given index.
	function automatic logic [7:0] target_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h54;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h72;
			3'd3:    c = 8'h67;
			3'd4:    c = 8'h65;
			3'd5:    c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// One byte of the reflected CRC-32, eight bit steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/dfu_image_validator_unit.sv
// ----------------------------------------------------------------------------
// dfu_image_validator_unit
// Checks a DfuSe image streamed one byte per item and reports status, CRCs
// and header fields on the final byte.
// ----------------------------------------------------------------------------
// Result path: a final byte is accepted into the input register, then moved
// into the result register.
// Throughput: one byte per cycle; a final byte waits in the input register
// only while the result register holds an item that is not yet taken.
// Reset: arst_n returns the position, flags, captures, window and CRC to their
// reset values at once; the same values are restored after every final byte.
module dfu_image_validator_unit #(
	parameter int unsigned POSITION_BITS = dfu_iv_pkg::POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [31:0]               computed_crc,
	output logic [31:0]               stored_crc,
	output logic [31:0]               load_address,
	output logic [31:0]               image_size
);
	import dfu_iv_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        final_s1;
	step_t       step;
	hdr_flags_t  flags;
	logic [31:0] address_nx;
	logic [31:0] size_nx;
	logic [31:0] crc_nx;
	logic [31:0] stored_nx;
	logic        suffix_ok;
	status_t     status_nx;

	// A byte leaves the input register unless it is final and the result
	// register is still full.
	always_comb begin
		step.fire = valid_s1 && (!final_s1 || !out_valid || out_ready);
		step.last = final_s1;
		in_ready  = !valid_s1 || step.fire;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	dfu_iv_hdr #(
		.POSITION_BITS(POSITION_BITS)
	) u_hdr (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (data_s1),
		.flags           (flags),
		.load_address_nx (address_nx),
		.image_size_nx   (size_nx)
	);

	dfu_iv_tail u_tail (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (data_s1),
		.crc_en          (!flags.len_lt5),
		.computed_crc_nx (crc_nx),
		.stored_crc_nx   (stored_nx),
		.suffix_ok       (suffix_ok)
	);

	// Status in priority order.
	always_comb begin
		if (flags.len_lt5) begin
			status_nx = ST_SHORT;
		end else if (!flags.prefix_ok) begin
			status_nx = ST_PREFIX;
		end else if (flags.len_lt17) begin
			status_nx = ST_SHORT;
		end else if (!flags.target_ok) begin
			status_nx = ST_TARGET;
		end else if (!suffix_ok) begin
			status_nx = ST_SUFFIX;
		end else if (crc_nx != stored_nx) begin
			status_nx = ST_CRC;
		end else if (flags.len_lt293) begin
			status_nx = ST_SHORT;
		end else begin
			status_nx = ST_OK;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step.fire && step.last) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && step.last) begin
			status       <= status_nx;
			computed_crc <= crc_nx;
			stored_crc   <= stored_nx;
			load_address <= address_nx;
			image_size   <= size_nx;
		end
	end

endmodule

FILE: hw/rtl/dfu_iv_hdr.sv
// ----------------------------------------------------------------------------
// dfu_iv_hdr
// Byte position counter, prefix and target signature checks and capture of
// the start address and image size header fields.
// ----------------------------------------------------------------------------
module dfu_iv_hdr #(
	parameter int unsigned POSITION_BITS = dfu_iv_pkg::POSITION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dfu_iv_pkg::step_t       step,
	input  logic [7:0]              data_byte,
	output dfu_iv_pkg::hdr_flags_t  flags,
	output logic [31:0]             load_address_nx,
	output logic [31:0]             image_size_nx
);
	import dfu_iv_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] position_q;
	logic                     prefix_q;
	logic                     target_q;
	logic [31:0]              address_q;
	logic [31:0]              size_q;

	logic                     in_prefix;
	logic                     in_target;
	logic                     in_address;
	logic                     in_size;
	logic [2:0]               target_idx;
	logic [1:0]               address_lane;
	logic [1:0]               size_lane;

	// Decode where the current byte falls in the header.
	always_comb begin
		in_prefix    = position_q < POSITION_BITS'(PREFIX_LEN);
		in_target    = (position_q >= POSITION_BITS'(TARGET_AT)) &&
		               (position_q < POSITION_BITS'(TARGET_AT + TARGET_LEN));
		in_address   = (position_q >= POSITION_BITS'(ADDRESS_AT)) &&
		               (position_q < POSITION_BITS'(ADDRESS_AT + 4));
		in_size      = (position_q >= POSITION_BITS'(SIZE_AT)) &&
		               (position_q < POSITION_BITS'(SIZE_AT + 4));
		target_idx   = 3'(position_q - POSITION_BITS'(TARGET_AT));
		address_lane = 2'(position_q - POSITION_BITS'(ADDRESS_AT));
		size_lane    = 2'(position_q - POSITION_BITS'(SIZE_AT));
	end

	// Flags and captures with the current byte folded in.
	always_comb begin
		flags.prefix_ok = prefix_q &&
		                  !(in_prefix && (data_byte != prefix_char(position_q[2:0])));
		flags.target_ok = target_q &&
		                  !(in_target && (data_byte != target_char(target_idx)));
		flags.len_lt5   = position_q < POSITION_BITS'(PREFIX_LEN - 1);
		flags.len_lt17  = position_q < POSITION_BITS'(TARGET_AT + TARGET_LEN - 1);
		flags.len_lt293 = position_q < POSITION_BITS'(HEADER_END - 1);

		load_address_nx = address_q;
		if (in_address) begin
			load_address_nx[8*address_lane +: 8] = data_byte;
		end
		image_size_nx = size_q;
		if (in_size) begin
			image_size_nx[8*size_lane +: 8] = data_byte;
		end
	end

	// Header state; the final byte returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			prefix_q   <= 1'b1;
			target_q   <= 1'b1;
			address_q  <= '0;
			size_q     <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				position_q <= '0;
				prefix_q   <= 1'b1;
				target_q   <= 1'b1;
				address_q  <= '0;
				size_q     <= '0;
			end else begin
				if (position_q != POS_MAX) begin
					position_q <= position_q + 1'b1;
				end
				prefix_q  <= flags.prefix_ok;
				target_q  <= flags.target_ok;
				address_q <= load_address_nx;
				size_q    <= image_size_nx;
			end
		end
	end

endmodule

FILE: hw/rtl/dfu_iv_tail.sv
// ----------------------------------------------------------------------------
// dfu_iv_tail
// Eight-byte tail window and the CRC-32 register. Bytes enter the CRC once
// they leave the four-byte delay, so the stored CRC never enters it.
// ----------------------------------------------------------------------------
module dfu_iv_tail (
	input  logic              clk,
	input  logic              arst_n,
	input  dfu_iv_pkg::step_t step,
	input  logic [7:0]        data_byte,
	input  logic              crc_en,
	output logic [31:0]       computed_crc_nx,
	output logic [31:0]       stored_crc_nx,
	output logic              suffix_ok
);
	import dfu_iv_pkg::*;

	logic [31:0] crc_q;
	logic [7:0]  win_q [8];

	// CRC update, stored CRC and suffix check as seen after this byte.
	always_comb begin
		computed_crc_nx = crc_en ? crc32_byte(crc_q, win_q[3]) : crc_q;
		stored_crc_nx   = {data_byte, win_q[0], win_q[1], win_q[2]};
		suffix_ok       = (win_q[6] == SUFFIX_U) && (win_q[5] == SUFFIX_F) &&
		                  (win_q[4] == SUFFIX_D);
	end

	// Window shifts newest first; the final byte clears it with the CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			for (int k = 0; k < 8; k++) begin
				win_q[k] <= '0;
			end
		end else if (step.fire) begin
			if (step.last) begin
				crc_q <= CRC_INIT;
				for (int k = 0; k < 8; k++) begin
					win_q[k] <= '0;
				end
			end else begin
				crc_q    <= computed_crc_nx;
				win_q[0] <= data_byte;
				for (int k = 1; k < 8; k++) begin
					win_q[k] <= win_q[k-1];
				end
			end
		end
	end

endmodule
